@@ design/usv_pkg.sv @@
// usv_pkg: constants and the scan state type of the utf-8 sequence validator
// depends on nothing; used by utf8_sequence_validator_unit
`timescale 1ns / 1ps

package usv_pkg;

    localparam logic [7:0] AsciiMax   = 8'h7F;
    localparam logic [7:0] NulByte    = 8'h00;
    localparam logic [7:0] Lead2Min   = 8'hC2;
    localparam logic [7:0] Lead2Max   = 8'hDF;
    localparam logic [7:0] Lead3Min   = 8'hE0;
    localparam logic [7:0] Lead3Surr  = 8'hED;
    localparam logic [7:0] Lead3Max   = 8'hEF;
    localparam logic [7:0] Lead4Min   = 8'hF0;
    localparam logic [7:0] Lead4Max   = 8'hF4;
    localparam logic [7:0] ContMin    = 8'h80;
    localparam logic [7:0] ContMax    = 8'hBF;
    localparam logic [7:0] ContMask   = 8'hC0;
    localparam logic [7:0] E0SecondLo = 8'hA0;
    localparam logic [7:0] EdSecondHi = 8'h9F;
    localparam logic [7:0] F0SecondLo = 8'h90;
    localparam logic [7:0] F4SecondHi = 8'h8F;

    localparam logic [1:0] DueNone  = 2'd0;
    localparam logic [1:0] DueOne   = 2'd1;
    localparam logic [1:0] DueTwo   = 2'd2;
    localparam logic [1:0] DueThree = 2'd3;

    typedef struct packed {
        logic [1:0] due;
        logic       pending;
        logic [7:0] second_lo;
        logic [7:0] second_hi;
        logic       failed;
    } t_scan_state;

    localparam t_scan_state ScanReset = '{
        due:       DueNone,
        pending:   1'b0,
        second_lo: ContMin,
        second_hi: ContMax,
        failed:    1'b0
    };

endpackage

@@ design/utf8_sequence_validator_unit.sv @@
// utf8_sequence_validator_unit: strict utf-8 checker, one byte per beat
// depends on usv_pkg
`timescale 1ns / 1ps

// Takes one byte per clock and gives one verdict (o_valid_res) on each byte
// marked last: 1 when the sequence is well-formed utf-8 with no NUL, no
// overlong form, no surrogate, nothing above U+10FFFF and no truncated
// character. A byte is held in the input register, is decoded against
// the scan state and, if last, its verdict lands in the output register,
// which drives o_valid_res. The sustained rate is one byte per cycle;
// the input stalls only while a verdict is held in the output register and a
// further last byte waits behind it.
module utf8_sequence_validator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_valid_res
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_last;
    usv_pkg::t_scan_state r_state;
    usv_pkg::t_scan_state n_state;
    usv_pkg::t_scan_state n_scan;
    logic                 r_out_valid;
    logic                 r_out_res;
    logic                 n_res;
    logic                 advance;
    logic                 in_beat;

    assign advance    = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_beat    = i_in_valid && o_in_ready;

    always_comb begin
        n_scan = r_state;
        if (!r_state.failed) begin
            if (r_state.due == usv_pkg::DueNone) begin
                if (r_byte == usv_pkg::NulByte) begin
                    n_scan.failed = 1'b1;
                end else if (r_byte <= usv_pkg::AsciiMax) begin
                    n_scan = r_state;
                end else if (r_byte >= usv_pkg::Lead2Min && r_byte <= usv_pkg::Lead2Max) begin
                    n_scan.due       = usv_pkg::DueOne;
                    n_scan.pending   = 1'b1;
                    n_scan.second_lo = usv_pkg::ContMin;
                    n_scan.second_hi = usv_pkg::ContMax;
                end else if (r_byte >= usv_pkg::Lead3Min && r_byte <= usv_pkg::Lead3Max) begin
                    n_scan.due       = usv_pkg::DueTwo;
                    n_scan.pending   = 1'b1;
                    n_scan.second_lo = (r_byte == usv_pkg::Lead3Min) ?
                                       usv_pkg::E0SecondLo : usv_pkg::ContMin;
                    n_scan.second_hi = (r_byte == usv_pkg::Lead3Surr) ?
                                       usv_pkg::EdSecondHi : usv_pkg::ContMax;
                end else if (r_byte >= usv_pkg::Lead4Min && r_byte <= usv_pkg::Lead4Max) begin
                    n_scan.due       = usv_pkg::DueThree;
                    n_scan.pending   = 1'b1;
                    n_scan.second_lo = (r_byte == usv_pkg::Lead4Min) ?
                                       usv_pkg::F0SecondLo : usv_pkg::ContMin;
                    n_scan.second_hi = (r_byte == usv_pkg::Lead4Max) ?
                                       usv_pkg::F4SecondHi : usv_pkg::ContMax;
                end else begin
                    n_scan.failed = 1'b1;
                end
            end else if (r_state.pending) begin
                if (r_byte < r_state.second_lo || r_byte > r_state.second_hi) begin
                    n_scan.failed = 1'b1;
                end else begin
                    n_scan.pending   = 1'b0;
                    n_scan.second_lo = usv_pkg::ContMin;
                    n_scan.second_hi = usv_pkg::ContMax;
                    n_scan.due       = r_state.due - 2'd1;
                end
            end else if ((r_byte & usv_pkg::ContMask) != usv_pkg::ContMin) begin
                n_scan.failed = 1'b1;
            end else begin
                n_scan.due = r_state.due - 2'd1;
            end
        end
        n_res   = !n_scan.failed && (n_scan.due == usv_pkg::DueNone);
        n_state = r_last ? usv_pkg::ScanReset : n_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= usv_pkg::ScanReset;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
        if (advance && r_last) begin
            r_out_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_out_res;

endmodule

@@ design/usv_checker.sv @@
// usv_checker: port-level checks of utf8_sequence_validator_unit
// depends on utf8_sequence_validator_unit; attached by bind
`timescale 1ns / 1ps

module usv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_byte_value,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_valid_res
);

    // a held verdict does not change or vanish
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_valid_res))
        else $error("verdict dropped or changed while stalled");

    // input stalls only behind a pending verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output register");

    // no verdict right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict shown after reset");

    // a verdict leaves only when taken
    a_out_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("verdict lost without a beat");

    // a waiting input beat holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_byte_value) && $stable(i_last_byte))
        else $error("input beat changed while stalled");

endmodule

bind utf8_sequence_validator_unit usv_checker u_usv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_byte_value (i_byte_value),
    .i_last_byte  (i_last_byte),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_valid_res  (o_valid_res)
);

@@ tb/utf8_sequence_validator_unit_test.sv @@
// utf8_sequence_validator_unit_test: self-checking bench for the utf-8 sequence validator
// drives byte beats, predicts or looks up each verdict, compares; needs usv_pkg and the unit
`timescale 1ns / 1ps

module utf8_sequence_validator_unit_test;

    localparam int CycleLimit = 200_000;

    typedef struct packed {
        logic [7:0] b_val;
        logic       is_last;
        logic       typed;
        logic       want;
    } t_dir_row;

    localparam t_dir_row DirRows [25] = '{
        '{8'h41, 1'b1, 1'b1, 1'b1},
        '{8'h00, 1'b1, 1'b1, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b0},
        '{8'hC0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0},
        '{8'hC2, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b0},
        '{8'hDF, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b1, 1'b0},
        '{8'hE0, 1'b0, 1'b0, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0},
        '{8'hED, 1'b0, 1'b0, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 1'b0},
        '{8'hE2, 1'b1, 1'b1, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_last_byte  = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_valid_res;

    logic [1:0] scan_due;
    logic       scan_second;
    logic [7:0] scan_lo;
    logic [7:0] scan_hi;
    logic       scan_failed;

    logic       verdict_q [$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         mismatch_count = 0;
    int         bytes_sent     = 0;
    int         sequences_sent = 0;
    int         verdicts_checked = 0;
    int         valid_verdicts = 0;
    int         cycle_count    = 0;

    utf8_sequence_validator_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_valid_res  (o_valid_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic clear_scan();
        scan_due    = usv_pkg::DueNone;
        scan_second = 1'b0;
        scan_lo     = usv_pkg::ContMin;
        scan_hi     = usv_pkg::ContMax;
        scan_failed = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b_val, input logic is_last,
                             output logic verdict);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = usv_pkg::ContMin;
        hi = usv_pkg::ContMax;
        verdict = 1'b0;
        if (!scan_failed) begin
            if (scan_due == usv_pkg::DueNone) begin
                if (b_val == usv_pkg::NulByte ||
                    (b_val > usv_pkg::AsciiMax && b_val < usv_pkg::Lead2Min) ||
                    b_val > usv_pkg::Lead4Max) begin
                    scan_failed = 1'b1;
                end else if (b_val > usv_pkg::AsciiMax) begin
                    if (b_val <= usv_pkg::Lead2Max) begin
                        scan_due = usv_pkg::DueOne;
                    end else if (b_val <= usv_pkg::Lead3Max) begin
                        scan_due = usv_pkg::DueTwo;
                        if (b_val == usv_pkg::Lead3Min) lo = usv_pkg::E0SecondLo;
                        else if (b_val == usv_pkg::Lead3Surr) hi = usv_pkg::EdSecondHi;
                    end else begin
                        scan_due = usv_pkg::DueThree;
                        if (b_val == usv_pkg::Lead4Min) lo = usv_pkg::F0SecondLo;
                        else if (b_val == usv_pkg::Lead4Max) hi = usv_pkg::F4SecondHi;
                    end
                    scan_second = 1'b1;
                    scan_lo     = lo;
                    scan_hi     = hi;
                end
            end else if (scan_second) begin
                if (b_val < scan_lo || b_val > scan_hi) begin
                    scan_failed = 1'b1;
                end else begin
                    scan_second = 1'b0;
                    scan_lo     = usv_pkg::ContMin;
                    scan_hi     = usv_pkg::ContMax;
                    scan_due    = scan_due - 2'd1;
                end
            end else if ((b_val & usv_pkg::ContMask) != usv_pkg::ContMin) begin
                scan_failed = 1'b1;
            end else begin
                scan_due = scan_due - 2'd1;
            end
        end
        if (is_last) begin
            verdict = !scan_failed && scan_due == usv_pkg::DueNone;
            clear_scan();
        end
    endtask

    task automatic send_beat(input logic [7:0] b_val, input logic is_last,
                             input logic typed, input logic want);
        logic pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_value <= b_val;
        i_last_byte  <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        scan_byte(b_val, is_last, pred);
        bytes_sent++;
        if (is_last) begin
            verdict_q.push_back(typed ? want : pred);
            sequences_sent++;
        end
    endtask

    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int quota, input int s_pct, input int r_pct);
        int         start_bytes;
        int         pos;
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] seq_bytes [$];
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        start_bytes    = bytes_sent;
        while (bytes_sent - start_bytes < quota) begin
            seq_bytes.delete();
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(1, 4)) seq_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    lo = usv_pkg::ContMin;
                    hi = usv_pkg::ContMax;
                    case ($urandom_range(0, 3))
                        0: seq_bytes.push_back(8'($urandom_range(1, 127)));
                        1: begin
                            seq_bytes.push_back(8'($urandom_range(usv_pkg::Lead2Min,
                                                                  usv_pkg::Lead2Max)));
                            seq_bytes.push_back(8'($urandom_range(usv_pkg::ContMin,
                                                                  usv_pkg::ContMax)));
                        end
                        2: begin
                            lead = 8'($urandom_range(usv_pkg::Lead3Min, usv_pkg::Lead3Max));
                            if (lead == usv_pkg::Lead3Min) lo = usv_pkg::E0SecondLo;
                            else if (lead == usv_pkg::Lead3Surr) hi = usv_pkg::EdSecondHi;
                            seq_bytes.push_back(lead);
                            seq_bytes.push_back(8'($urandom_range(lo, hi)));
                            seq_bytes.push_back(8'($urandom_range(usv_pkg::ContMin,
                                                                  usv_pkg::ContMax)));
                        end
                        default: begin
                            lead = 8'($urandom_range(usv_pkg::Lead4Min, usv_pkg::Lead4Max));
                            if (lead == usv_pkg::Lead4Min) lo = usv_pkg::F0SecondLo;
                            else if (lead == usv_pkg::Lead4Max) hi = usv_pkg::F4SecondHi;
                            seq_bytes.push_back(lead);
                            seq_bytes.push_back(8'($urandom_range(lo, hi)));
                            seq_bytes.push_back(8'($urandom_range(usv_pkg::ContMin,
                                                                  usv_pkg::ContMax)));
                            seq_bytes.push_back(8'($urandom_range(usv_pkg::ContMin,
                                                                  usv_pkg::ContMax)));
                        end
                    endcase
                end
                // occasionally break a well-formed sequence
                if ($urandom_range(0, 3) == 0) begin
                    pos = $urandom_range(0, seq_bytes.size() - 1);
                    case ($urandom_range(0, 2))
                        0: seq_bytes[pos] = 8'($urandom_range(0, 255));
                        1: if (seq_bytes.size() > 1) void'(seq_bytes.pop_back());
                        default: seq_bytes.insert(pos, 8'($urandom_range(0, 255)));
                    endcase
                end
            end
            foreach (seq_bytes[k]) begin
                send_beat(seq_bytes[k], k == seq_bytes.size() - 1, 1'b0, 1'b0);
            end
        end
        drain_verdicts();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with none expected", o_valid_res));
            end else begin
                if (o_valid_res !== verdict_q[0]) begin
                    report_mismatch($sformatf("verdict %0b, expected %0b",
                                              o_valid_res, verdict_q[0]));
                end
                if (verdict_q[0]) valid_verdicts++;
                verdicts_checked++;
                void'(verdict_q.pop_front());
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        clear_scan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 15;
        recv_stall_pct = 84;
        foreach (DirRows[i]) begin
            send_beat(DirRows[i].b_val, DirRows[i].is_last, DirRows[i].typed, DirRows[i].want);
        end
        drain_verdicts();

        run_random_phase(430, 15, 84);
        run_random_phase(430, 84, 15);
        run_random_phase(440, 0, 0);

        repeat (8) @(posedge i_clk);
        $display("sent %0d bytes in %0d sequences under mixed sender and receiver stalls",
                 bytes_sent, sequences_sent);
        $display("checked %0d verdicts: %0d well-formed, %0d rejected",
                 verdicts_checked, valid_verdicts, verdicts_checked - valid_verdicts);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
